// File: rtl/sha256_pkg.sv
// Shared types, constants and functions of the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sha256_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_DIGEST
    } t_state;

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      shift_en;    // shift one byte into the block buffer
        t_byte_sel byte_sel;
        logic      len_load;    // capture the message bit length
        logic      block_inc;   // one more full block absorbed
        logic      round_start; // load working vars from hash state
        logic      round_en;    // run one compression round
        logic      hash_add;    // fold working vars into hash state
        logic      digest_load; // move hash to output, restore IV
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] byte_cnt;   // bytes pending in the block buffer
        logic       round_last; // round 63 is running
        logic       out_busy;   // digest words still waiting
    } t_stat;

    localparam logic [5:0] LEN_POS = 6'd56; // first byte of the length field

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    // Initial hash values
    function automatic logic [31:0] sha_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // Round constants
    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_ctrl.sv
// Controller of the SHA-256 stream hasher: sequences absorb, padding,
// compression rounds and digest hand-off. Depends on sha256_pkg.
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_action,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_fin;     // padding of a finished message in progress
    logic   r_first;   // next pad byte is 0x80
    logic   r_len_ok;  // current block carries the length field
    logic   w_accept;
    logic   w_blk_full;

    assign w_blk_full = (i_stat.byte_cnt == 6'd63);

    // Command and handshake outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.byte_sel = SEL_DATA;
        o_in_ready = 1'b0;
        w_accept   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // a finish waits until the previous digest has drained
                o_in_ready = !(i_action && i_stat.out_busy);
                w_accept   = i_in_valid && o_in_ready;
                if (w_accept) begin
                    if (!i_action) begin
                        o_cmd.shift_en = 1'b1;
                        if (w_blk_full) begin
                            o_cmd.block_inc   = 1'b1;
                            o_cmd.round_start = 1'b1;
                        end
                    end else begin
                        o_cmd.len_load = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.shift_en = 1'b1;
                if (r_first) begin
                    o_cmd.byte_sel = SEL_PAD80;
                end else if (r_len_ok && (i_stat.byte_cnt >= LEN_POS)) begin
                    o_cmd.byte_sel = SEL_LEN;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (w_blk_full) begin
                    o_cmd.block_inc   = 1'b1;
                    o_cmd.round_start = 1'b1;
                end
            end
            ST_COMP:   o_cmd.round_en    = 1'b1;
            ST_ADD:    o_cmd.hash_add    = 1'b1;
            ST_DIGEST: o_cmd.digest_load = 1'b1;
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action) begin
                        n_state = ST_PAD;
                    end else if (w_blk_full) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                if (w_blk_full) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (i_stat.round_last) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len_ok) begin
                    n_state = ST_DIGEST;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_DIGEST: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State and padding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fin    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_action) begin
                r_fin    <= 1'b1;
                r_first  <= 1'b1;
                r_len_ok <= (i_stat.byte_cnt < LEN_POS);
            end
            if (r_state == ST_PAD) begin
                r_first <= 1'b0;
            end
            if ((r_state == ST_ADD) && r_fin) begin
                r_len_ok <= 1'b1;
            end
            if (r_state == ST_DIGEST) begin
                r_fin <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sha256_dp.sv
// Datapath of the SHA-256 stream hasher: block buffer and message schedule,
// round logic, hash state and digest output register. Depends on sha256_pkg.
`default_nettype none

module sha256_dp
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_word,
    output logic [2:0]       o_out_index,
    output logic             o_out_last
);

    logic [511:0] r_blk;       // 64-byte buffer, later the 16-word schedule
    logic [5:0]   r_cnt;
    logic [63:0]  r_len;
    logic [54:0]  r_blocks;    // full blocks absorbed, bit count / 512
    logic [31:0]  r_hash [8];
    logic [31:0]  r_v [8];     // working variables a..h
    logic [5:0]   r_rnd;
    logic [31:0]  r_out [8];
    logic         r_out_vld;
    logic [2:0]   r_out_idx;

    logic [7:0]   w_byte;
    logic [31:0]  w_w0, w_w1, w_w9, w_w14, w_wnew;
    logic [31:0]  w_t1, w_t2, w_ch, w_maj;
    logic         w_out_acc;

    // Byte source
    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA:  w_byte = i_data_byte;
            SEL_PAD80: w_byte = 8'h80;
            SEL_ZERO:  w_byte = 8'h00;
            SEL_LEN:   w_byte = r_len[63:56];
            default:   w_byte = 8'h00;
        endcase
    end

    // Schedule taps: word 0 is the oldest
    assign w_w0   = r_blk[511:480];
    assign w_w1   = r_blk[479:448];
    assign w_w9   = r_blk[223:192];
    assign w_w14  = r_blk[63:32];
    assign w_wnew = small_sigma1(w_w14) + w_w9 + small_sigma0(w_w1) + w_w0;

    // One compression round
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + big_sigma1(r_v[4]) + w_ch + sha_k(r_rnd) + w_w0;
    assign w_t2  = big_sigma0(r_v[0]) + w_maj;

    // Buffer / schedule shift line and length field
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_blk <= {r_blk[503:0], w_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_wnew};
        end
        if (i_cmd.len_load) begin
            r_len <= {r_blocks, r_cnt, 3'b000};
        end else if (i_cmd.shift_en && (i_cmd.byte_sel == SEL_LEN)) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    // Byte and block counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_blocks <= '0;
        end else begin
            if (i_cmd.shift_en) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (i_cmd.digest_load) begin
                r_blocks <= '0;
            end else if (i_cmd.block_inc) begin
                r_blocks <= r_blocks + 55'd1;
            end
        end
    end

    // Working variables and round counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
            r_rnd <= '0;
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
            r_rnd  <= r_rnd + 6'd1;
        end
    end

    // Hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.digest_load) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha_iv(3'(i));
            end
        end else if (i_cmd.hash_add) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    // Digest output register, word 0 first
    assign w_out_acc = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.digest_load) begin
            for (int i = 0; i < 8; i++) begin
                r_out[i] <= r_hash[i];
            end
        end else if (w_out_acc) begin
            for (int i = 0; i < 7; i++) begin
                r_out[i] <= r_out[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out_idx <= '0;
        end else if (i_cmd.digest_load) begin
            r_out_vld <= 1'b1;
            r_out_idx <= '0;
        end else if (w_out_acc) begin
            r_out_idx <= r_out_idx + 3'd1;
            if (r_out_idx == 3'd7) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out[0];
    assign o_out_index = r_out_idx;
    assign o_out_last  = (r_out_idx == 3'd7);

    assign o_stat.byte_cnt   = r_cnt;
    assign o_stat.round_last = (r_rnd == 6'd63);
    assign o_stat.out_busy   = r_out_vld;

endmodule

`default_nettype wire

// File: rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher: absorbs one message byte per input transaction and
// delivers the 256-bit digest as eight 32-bit words when a finish transaction
// arrives. Bytes are taken one per cycle while the controller is idle; the
// 64th byte of a block starts the compression, which runs one round per cycle
// in a single shared round unit, after which the ADD state folds the result
// into the hash state; the input stalls through both. A finish stalls the
// input while padding bytes are shifted in one per cycle (64 minus the
// pending bytes, plus 64 more when 56 or more were pending), each padded block
// is compressed, and the DIGEST state moves the digest to the output
// register. The eight words then drain at the output's pace while new message
// bytes are already accepted; a further finish waits for the drain to end.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
`default_nettype none

module sha256_stream_hasher_core
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] action (0 absorb, 1 finish)
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_axis_tuser,   // [2:0] word_index
    output logic             o_m_axis_tlast    // last_word
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_action   (i_s_axis_tuser[0]),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Buffer, rounds, hash state and output register
    sha256_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_data_byte (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_word  (o_m_axis_tdata),
        .o_out_index (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

    // A finish transaction is never taken while a digest is still draining
    a_finish_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] |-> !o_m_axis_tvalid)
        else $error("finish accepted while digest still pending");

    // Input is stalled while compression rounds run
    a_stall_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.round_en |-> !o_s_axis_tready)
        else $error("input ready during compression");

    // Digest words come out in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
        o_m_axis_tvalid && (o_m_axis_tuser == 3'($past(o_m_axis_tuser) + 3'd1)))
        else $error("digest word sequence broken");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for sha256_stream_hasher_core: byte stream in, digest words out.
// Holds its own SHA-256 predictor and drives random idle gaps on both stream sides.
// Depends on the RTL top level only.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RAND_ITEMS   = 230;
    localparam int MAX_IDLE     = 4;

    typedef enum logic {
        ACT_ABSORB = 1'b0,
        ACT_FINISH = 1'b1
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] data;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_res;

    // Clock, reset and DUT-facing signals
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic [0:0]  s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    sha256_stream_hasher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] data_byte
        .i_s_axis_tuser  (s_tuser),   // [0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] digest_word
        .o_m_axis_tuser  (o_m_axis_tuser),  // [2:0] word_index
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // SHA-256 constants
    logic [31:0] round_k [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] hash_iv [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Predictor state
    logic [31:0] hash_st [0:7];
    logic [7:0]  blk_buf [0:63];
    int          blk_fill;
    logic [63:0] msg_bits;

    // Stimulus and expected digest words
    t_byte_item  byte_q [$];
    t_digest_res digest_q [$];
    int          total_items;
    int          accepted_cnt;
    int          err_cnt;
    int          cycle_cnt;
    bit          in_fire;
    bit          out_fire;
    int          src_gap;
    int          sink_wait;
    bit          src_calm;
    bit          sink_calm;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64-round compression of blk_buf into hash_st
    function automatic void fold_block();
        logic [31:0] w [0:63];
        logic [31:0] v [0:7];
        logic [31:0] s0, s1, t1, t2, ch, mj;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + round_k[i] + w[i];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_st[i] = hash_iv[i];
        blk_fill = 0;
        msg_bits = 64'd0;
    endfunction

    // Update the hash state for one accepted byte transaction
    task automatic predict_hash(input t_action act, input logic [7:0] b);
        logic [63:0] len;
        t_digest_res r;
        if (act == ACT_ABSORB) begin
            blk_buf[blk_fill] = b;
            blk_fill++;
            if (blk_fill == 64) begin
                fold_block();
                msg_bits = msg_bits + 64'd512;
                blk_fill = 0;
            end
        end else begin
            // padding: 0x80, zeros, length; extra block when the tail is 56+ bytes
            blk_buf[blk_fill] = 8'h80;
            for (int i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
            if (blk_fill >= 56) begin
                fold_block();
                for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
            end
            len = msg_bits + 64'(blk_fill) * 64'd8;
            for (int i = 0; i < 8; i++) blk_buf[63-i] = len[8*i +: 8];
            fold_block();
            for (int i = 0; i < 8; i++) begin
                r.word = hash_st[i];
                r.idx  = 3'(i);
                r.last = (i == 7);
                digest_q.push_back(r);
            end
            restart_message();
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_item(input t_action act, input logic [7:0] b);
        t_byte_item it;
        it.action = act;
        it.data   = b;
        byte_q.push_back(it);
        total_items++;
    endtask

    // Random message content followed by a finish with a don't-care byte
    task automatic add_message(input int len);
        for (int i = 0; i < len; i++) add_item(ACT_ABSORB, 8'($urandom_range(0, 255)));
        add_item(ACT_FINISH, 8'($urandom_range(0, 255)));
    endtask

    function automatic int draw_idle(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Monitor: sample both handshakes, check results, feed the predictor
    always @(posedge i_clk) begin
        t_digest_res got, want;
        in_fire  = i_rst_n && s_tvalid && o_s_axis_tready;
        out_fire = i_rst_n && o_m_axis_tvalid && m_tready;
        if (out_fire) begin
            got.word = o_m_axis_tdata;
            got.idx  = o_m_axis_tuser;
            got.last = o_m_axis_tlast;
            if (digest_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected digest word %h idx %0d last %0b",
                                        got.word, got.idx, got.last));
            end else begin
                want = digest_q.pop_front();
                if (got !== want) begin
                    flag_mismatch($sformatf("word %h/%h idx %0d/%0d last %0b/%0b (got/exp)",
                                            got.word, want.word, got.idx, want.idx,
                                            got.last, want.last));
                end
            end
        end
        if (in_fire) begin
            predict_hash(t_action'(s_tuser[0]), s_tdata);
            accepted_cnt++;
        end
    end

    // Driver: one byte transaction at a time, random gap after each
    always @(negedge i_clk) begin
        t_byte_item it;
        if (i_rst_n && (!s_tvalid || in_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                it = byte_q.pop_front();
                s_tuser  <= it.action;
                s_tdata  <= it.data;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 19) == 0) src_calm = ~src_calm;
                src_gap = draw_idle(src_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each accepted digest word
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if ($urandom_range(0, 9) == 0) sink_calm = ~sink_calm;
                sink_wait = draw_idle(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int rnd_items;
        int len;
        int sel;
        total_items  = 0;
        accepted_cnt = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        in_fire      = 0;
        out_fire     = 0;
        src_gap      = 0;
        sink_wait    = 0;
        src_calm     = 0;
        sink_calm    = 0;
        restart_message();

        // Directed: empty message, byte extremes, "abc", back-to-back finishes
        add_item(ACT_FINISH, 8'h00);
        add_item(ACT_ABSORB, 8'h00);
        add_item(ACT_ABSORB, 8'hff);
        add_item(ACT_ABSORB, 8'h80);
        add_item(ACT_ABSORB, 8'h7f);
        add_item(ACT_FINISH, 8'hff);
        add_item(ACT_ABSORB, 8'h61);
        add_item(ACT_ABSORB, 8'h62);
        add_item(ACT_ABSORB, 8'h63);
        add_item(ACT_FINISH, 8'h5a);
        add_item(ACT_FINISH, 8'ha5);

        // Random content: tails of 56 and 63 bytes and an exact block first
        rnd_items = total_items;
        add_message(56);
        add_message(64);
        add_message(63);
        while (total_items - rnd_items < RAND_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) len = $urandom_range(0, 12);
            else if (sel < 9) len = $urandom_range(50, 70);
            else len = $urandom_range(120, 130);
            // last message is cut short so the total stays near the target
            if (len > RAND_ITEMS - (total_items - rnd_items) - 1) begin
                len = RAND_ITEMS - (total_items - rnd_items) - 1;
            end
            add_message(len);
        end

        // Synchronous reset
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_items) @(posedge i_clk);
        while (digest_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_dp.sv
rtl/sha256_stream_hasher_core.sv
test/tb_top.sv
